@@ rtl/core/tsr_pkg.sv @@
// Shared constants and control/status types for the trapezoid span rasterizer.
`timescale 1ns / 1ps

package tsr_pkg;

  // Default coordinate and color widths
  localparam int COORD_BITS_DEF = 8;
  localparam int COLOR_BITS_DEF = 8;

  // Function codes carried by the input word
  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_NEXT  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;          // load both walkers from the input word
    logic step;          // take one walker step on the selected edge
    logic sel_right;     // 0 selects the left edge, 1 the right edge
    logic emit_span;     // write the current span into the output register
    logic emit_none;     // write an empty span into the output register
    logic clear_active;  // end the fill in progress
  } tsr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic active;    // a fill is in progress
    logic finished;  // selected walker sits on its end point
    logic y_step;    // selected walker takes its y step this cycle
    logic last;      // left walker is on the final row
  } tsr_status_t;

endpackage

@@ rtl/core/tsr_ctrl.sv @@
// Controller state machine that sequences walker steps and span output.
`timescale 1ns / 1ps

module tsr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tsr_pkg::tsr_status_t status,
  output tsr_pkg::tsr_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK_L = 3'd1;
  localparam logic [2:0] S_WALK_R = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_NONE   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Decode state into next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (in_func)
            tsr_pkg::FUNC_BEGIN: begin
              cmd.load  = 1'b1;
              state_nxt = S_EMIT;
            end
            tsr_pkg::FUNC_NEXT: begin
              state_nxt = status.active ? S_WALK_L : S_NONE;
            end
          endcase
        end
      end
      S_WALK_L: begin
        cmd.sel_right = 1'b0;
        if (status.finished) begin
          cmd.clear_active = 1'b1;
          state_nxt        = S_NONE;
        end else begin
          cmd.step = 1'b1;
          if (status.y_step) begin
            state_nxt = S_WALK_R;
          end
        end
      end
      S_WALK_R: begin
        cmd.sel_right = 1'b1;
        if (status.finished) begin
          cmd.clear_active = 1'b1;
          state_nxt        = S_NONE;
        end else begin
          cmd.step = 1'b1;
          if (status.y_step) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit_span    = 1'b1;
          cmd.clear_active = status.last;
          state_nxt        = S_IDLE;
        end
      end
      S_NONE: begin
        if (out_free) begin
          cmd.emit_none = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the output word until it is taken
  always_comb begin
    if (cmd.emit_span || cmd.emit_none) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/tsr_datapath.sv @@
// Edge walker registers, shared Bresenham step unit and output register.
`timescale 1ns / 1ps

module tsr_datapath #(
  parameter int COORD_BITS = tsr_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = tsr_pkg::COLOR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [COORD_BITS-1:0] in_top_left_x,
  input  logic [COORD_BITS-1:0] in_top_right_x,
  input  logic [COORD_BITS-1:0] in_bottom_left_x,
  input  logic [COORD_BITS-1:0] in_bottom_right_x,
  input  logic [COORD_BITS-1:0] in_top_y,
  input  logic [COORD_BITS-1:0] in_bottom_y,
  input  logic [COLOR_BITS-1:0] in_fill_color,
  input  tsr_pkg::tsr_cmd_t     cmd,
  output tsr_pkg::tsr_status_t  status,
  output logic [COORD_BITS:0]   out_span_left_x,
  output logic [COORD_BITS:0]   out_span_right_x,
  output logic [COORD_BITS-1:0] out_span_row,
  output logic [COLOR_BITS-1:0] out_span_color,
  output logic                  out_last_span,
  output logic                  out_span_valid
);

  localparam int EB = COORD_BITS + 2;

  // Walker state, index 0 is the left edge and 1 the right edge
  logic [COORD_BITS-1:0]  edge_x_r     [2];
  logic [COORD_BITS-1:0]  edge_y_r     [2];
  logic [COORD_BITS-1:0]  edge_end_x_r [2];
  logic [COORD_BITS-1:0]  edge_dx_r    [2];
  logic [COORD_BITS-1:0]  edge_dy_r    [2];
  logic                   edge_x_down_r[2];
  logic                   edge_y_down_r[2];
  logic signed [EB-1:0]   edge_error_r [2];
  logic [COORD_BITS-1:0]  end_row_r;
  logic [COLOR_BITS-1:0]  held_color_r;
  logic                   active_r;

  // Load values for both edges
  logic [COORD_BITS-1:0]  ld_x0  [2];
  logic [COORD_BITS-1:0]  ld_x1  [2];
  logic [COORD_BITS-1:0]  ld_dx  [2];
  logic [COORD_BITS-1:0]  ld_dy;
  logic                   ld_xdn [2];
  logic                   ld_ydn;
  logic signed [EB-1:0]   ld_err [2];

  // Shared step unit signals
  logic [COORD_BITS-1:0]  st_x, st_y, st_x_nxt, st_y_nxt;
  logic signed [EB-1:0]   st_e, st_ndx, st_dx, st_dy, st_e_nxt;
  logic                   st_xmove, st_ymove;

  // Work out deltas, directions and initial error on a begin word
  always_comb begin
    ld_x0[0] = in_top_left_x;
    ld_x0[1] = in_top_right_x;
    ld_x1[0] = in_bottom_left_x;
    ld_x1[1] = in_bottom_right_x;
    ld_ydn   = !(in_top_y < in_bottom_y);
    ld_dy    = ld_ydn ? (in_top_y - in_bottom_y) : (in_bottom_y - in_top_y);
    for (int k = 0; k < 2; k++) begin
      ld_xdn[k] = !(ld_x0[k] < ld_x1[k]);
      ld_dx[k]  = ld_xdn[k] ? (ld_x0[k] - ld_x1[k]) : (ld_x1[k] - ld_x0[k]);
      ld_err[k] = (ld_dx[k] > ld_dy) ? $signed({2'b00, ld_dx[k] >> 1})
                                     : -$signed({2'b00, ld_dy >> 1});
    end
  end

  // Take one Bresenham step on the selected edge
  always_comb begin
    st_x     = edge_x_r[cmd.sel_right];
    st_y     = edge_y_r[cmd.sel_right];
    st_e     = edge_error_r[cmd.sel_right];
    st_dx    = $signed({2'b00, edge_dx_r[cmd.sel_right]});
    st_dy    = $signed({2'b00, edge_dy_r[cmd.sel_right]});
    st_ndx   = -st_dx;
    st_xmove = (st_e > st_ndx);
    st_ymove = (st_e < st_dy);
    st_e_nxt = st_e - (st_xmove ? st_dy : '0) + (st_ymove ? st_dx : '0);
    st_x_nxt = st_x;
    st_y_nxt = st_y;
    if (st_xmove) begin
      st_x_nxt = edge_x_down_r[cmd.sel_right] ? (st_x - 1'b1) : (st_x + 1'b1);
    end
    if (st_ymove) begin
      st_y_nxt = edge_y_down_r[cmd.sel_right] ? (st_y - 1'b1) : (st_y + 1'b1);
    end
  end

  assign status.active   = active_r;
  assign status.finished = (st_x == edge_end_x_r[cmd.sel_right]) && (st_y == end_row_r);
  assign status.y_step   = st_ymove;
  assign status.last     = (edge_y_r[0] == end_row_r);

  // Load or advance the walkers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 2; k++) begin
        edge_x_r[k]      <= ld_x0[k];
        edge_y_r[k]      <= in_top_y;
        edge_end_x_r[k]  <= ld_x1[k];
        edge_dx_r[k]     <= ld_dx[k];
        edge_dy_r[k]     <= ld_dy;
        edge_x_down_r[k] <= ld_xdn[k];
        edge_y_down_r[k] <= ld_ydn;
        edge_error_r[k]  <= ld_err[k];
      end
      end_row_r    <= in_bottom_y;
      held_color_r <= in_fill_color;
    end else if (cmd.step) begin
      edge_x_r[cmd.sel_right]     <= st_x_nxt;
      edge_y_r[cmd.sel_right]     <= st_y_nxt;
      edge_error_r[cmd.sel_right] <= st_e_nxt;
    end
  end

  // Track whether a fill is in progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.load) begin
      active_r <= 1'b1;
    end else if (cmd.clear_active) begin
      active_r <= 1'b0;
    end
  end

  // Write the output word
  always_ff @(posedge clk) begin
    if (cmd.emit_span) begin
      out_span_left_x  <= {edge_x_r[0], 1'b0};
      out_span_right_x <= {edge_x_r[1], 1'b1};
      out_span_row     <= edge_y_r[0];
      out_span_color   <= held_color_r;
      out_last_span    <= status.last;
      out_span_valid   <= 1'b1;
    end else if (cmd.emit_none) begin
      out_span_left_x  <= '0;
      out_span_right_x <= '0;
      out_span_row     <= '0;
      out_span_color   <= '0;
      out_last_span    <= 1'b0;
      out_span_valid   <= 1'b0;
    end
  end

endmodule

@@ rtl/core/trapezoid_span_rasterizer.sv @@
// Top level of the trapezoid span rasterizer: controller plus datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Word
// in_       input      in_valid / in_ready   func, corner x values, top/bottom y, color
// out_      output     out_valid / out_ready span x range, row, color, last, valid flag
//
// A begin word loads both walkers and then gives its span from the emit state; a next
// word steps the left walker and then the right walker until each takes its y step,
// one Bresenham step per cycle through the single shared step unit, and then emits.
// A next word with no fill in progress answers with an empty span.
// Input is taken only while the controller is idle; a waiting output word does
// not block acceptance, but the next result waits for the output register.
// Synchronous active-low reset clears the controller and the fill flag and
// holds in_ready low.

module trapezoid_span_rasterizer #(
  parameter int COORD_BITS = tsr_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = tsr_pkg::COLOR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [COORD_BITS-1:0] in_top_left_x,
  input  logic [COORD_BITS-1:0] in_top_right_x,
  input  logic [COORD_BITS-1:0] in_bottom_left_x,
  input  logic [COORD_BITS-1:0] in_bottom_right_x,
  input  logic [COORD_BITS-1:0] in_top_y,
  input  logic [COORD_BITS-1:0] in_bottom_y,
  input  logic [COLOR_BITS-1:0] in_fill_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS:0]   out_span_left_x,
  output logic [COORD_BITS:0]   out_span_right_x,
  output logic [COORD_BITS-1:0] out_span_row,
  output logic [COLOR_BITS-1:0] out_span_color,
  output logic                  out_last_span,
  output logic                  out_span_valid
);

  tsr_pkg::tsr_cmd_t    cmd;
  tsr_pkg::tsr_status_t status;

  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tsr_datapath #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_top_left_x     (in_top_left_x),
    .in_top_right_x    (in_top_right_x),
    .in_bottom_left_x  (in_bottom_left_x),
    .in_bottom_right_x (in_bottom_right_x),
    .in_top_y          (in_top_y),
    .in_bottom_y       (in_bottom_y),
    .in_fill_color     (in_fill_color),
    .cmd               (cmd),
    .status            (status),
    .out_span_left_x   (out_span_left_x),
    .out_span_right_x  (out_span_right_x),
    .out_span_row      (out_span_row),
    .out_span_color    (out_span_color),
    .out_last_span     (out_last_span),
    .out_span_valid    (out_span_valid)
  );

endmodule

@@ rtl/core/tsr_checker.sv @@
// Port-level assertions for the trapezoid span rasterizer and their bind.
`timescale 1ns / 1ps

module tsr_checker #(
  parameter int COORD_BITS = tsr_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = tsr_pkg::COLOR_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS:0]   out_span_left_x,
  input logic [COORD_BITS:0]   out_span_right_x,
  input logic [COORD_BITS-1:0] out_span_row,
  input logic [COLOR_BITS-1:0] out_span_color,
  input logic                  out_last_span,
  input logic                  out_span_valid
);

  // An empty span carries all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_span_valid |->
      out_span_left_x == '0 && out_span_right_x == '0 && out_span_row == '0 &&
      out_span_color == '0 && !out_last_span)
    else $error("empty span with nonzero fields");

  // Only a real span can close a fill
  a_last_real: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_span |-> out_span_valid)
    else $error("last flag on an empty span");

  // Doubled x: span starts on an even column and ends on an odd one
  a_span_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_span_valid |-> !out_span_left_x[0] && out_span_right_x[0])
    else $error("span end points have wrong parity");

  // One word in work at a time: the input closes right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in work");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_span_left_x) &&
      $stable(out_span_right_x) && $stable(out_span_row) &&
      $stable(out_span_color) && $stable(out_last_span) && $stable(out_span_valid))
    else $error("stalled output word changed");

endmodule

bind trapezoid_span_rasterizer tsr_checker #(
  .COORD_BITS (COORD_BITS),
  .COLOR_BITS (COLOR_BITS)
) u_tsr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_span_left_x  (out_span_left_x),
  .out_span_right_x (out_span_right_x),
  .out_span_row     (out_span_row),
  .out_span_color   (out_span_color),
  .out_last_span    (out_last_span),
  .out_span_valid   (out_span_valid)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for the trapezoid span rasterizer: driver, span predictor, checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int CB = tsr_pkg::COORD_BITS_DEF;
  localparam int KB = tsr_pkg::COLOR_BITS_DEF;
  localparam int STALL_LIMIT = 10000;

  typedef struct packed {
    logic          func;
    logic [CB-1:0] top_left_x;
    logic [CB-1:0] top_right_x;
    logic [CB-1:0] bottom_left_x;
    logic [CB-1:0] bottom_right_x;
    logic [CB-1:0] top_y;
    logic [CB-1:0] bottom_y;
    logic [KB-1:0] fill_color;
  } word_t;

  localparam int WB = $bits(word_t);

  typedef struct packed {
    logic [CB:0]   left_x;
    logic [CB:0]   right_x;
    logic [CB-1:0] row;
    logic [KB-1:0] color;
    logic          last;
    logic          valid;
  } span_t;

  // Walk both trapezoid edges and queue the span each word should produce
  class span_tracker;
    bit [CB-1:0] walk_x[2];
    bit [CB-1:0] walk_y[2];
    bit [CB-1:0] stop_x[2];
    bit [CB-1:0] stop_row;
    int          run_x[2];
    int          run_y[2];
    bit          x_back[2];
    bit          y_back[2];
    int          slope_err[2];
    bit [KB-1:0] color;
    bit          filling;
    span_t       spans_due[$];
    int          errors;

    function void load_walker(int k, bit [CB-1:0] x0, bit [CB-1:0] y0,
                              bit [CB-1:0] x1, bit [CB-1:0] y1);
      run_x[k] = (x1 >= x0) ? int'(x1 - x0) : int'(x0 - x1);
      run_y[k] = (y1 >= y0) ? int'(y1 - y0) : int'(y0 - y1);
      walk_x[k] = x0;
      walk_y[k] = y0;
      stop_x[k] = x1;
      x_back[k] = !(x0 < x1);
      y_back[k] = !(y0 < y1);
      slope_err[k] = (run_x[k] > run_y[k]) ? run_x[k] / 2 : -(run_y[k] / 2);
    endfunction

    // Step one edge until its y moves; return 0 when the walker has no step left
    function bit step_walker(int k);
      int e;
      for (int n = 0; n < (4 << CB); n++) begin
        if (walk_x[k] == stop_x[k] && walk_y[k] == stop_row) return 1'b0;
        e = slope_err[k];
        if (e > -run_x[k]) begin
          slope_err[k] -= run_y[k];
          walk_x[k] = x_back[k] ? walk_x[k] - 1'b1 : walk_x[k] + 1'b1;
        end
        if (e < run_y[k]) begin
          slope_err[k] += run_x[k];
          walk_y[k] = y_back[k] ? walk_y[k] - 1'b1 : walk_y[k] + 1'b1;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void emit_span();
      span_t s;
      s.left_x  = {walk_x[0], 1'b0};
      s.right_x = {walk_x[1], 1'b1};
      s.row     = walk_y[0];
      s.color   = color;
      s.last    = (walk_y[0] == stop_row);
      s.valid   = 1'b1;
      if (s.last) filling = 1'b0;
      spans_due.push_back(s);
    endfunction

    function void emit_blank();
      spans_due.push_back('0);
    endfunction

    function void take_word(word_t w);
      if (w.func == tsr_pkg::FUNC_BEGIN) begin
        load_walker(0, w.top_left_x, w.top_y, w.bottom_left_x, w.bottom_y);
        load_walker(1, w.top_right_x, w.top_y, w.bottom_right_x, w.bottom_y);
        stop_row = w.bottom_y;
        color    = w.fill_color;
        filling  = 1'b1;
        emit_span();
      end else if (!filling) begin
        emit_blank();
      end else if (!step_walker(0) || !step_walker(1)) begin
        // a walker ran out before the last row: end the fill
        filling = 1'b0;
        emit_blank();
      end else begin
        emit_span();
      end
    endfunction

    function int field_bad(string name, int unsigned want, int unsigned got);
      if (want == got) return 0;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      return 1;
    endfunction

    function void match_span(span_t got);
      span_t want;
      if (spans_due.size() == 0) begin
        $display("%0t: unexpected span, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = spans_due.pop_front();
      errors += field_bad("span_left_x", 32'(want.left_x), 32'(got.left_x));
      errors += field_bad("span_right_x", 32'(want.right_x), 32'(got.right_x));
      errors += field_bad("span_row", 32'(want.row), 32'(got.row));
      errors += field_bad("span_color", 32'(want.color), 32'(got.color));
      errors += field_bad("last_span", 32'(want.last), 32'(got.last));
      errors += field_bad("span_valid", 32'(want.valid), 32'(got.valid));
    endfunction

    function int pending();
      return spans_due.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  word_t         offer;
  logic          out_valid;
  logic          out_ready;
  logic [CB:0]   out_span_left_x;
  logic [CB:0]   out_span_right_x;
  logic [CB-1:0] out_span_row;
  logic [KB-1:0] out_span_color;
  logic          out_last_span;
  logic          out_span_valid;

  span_tracker book;
  int          sent;
  int          words_in;
  int          idle_cycles;
  bit          steady;
  bit          long_hold_done;

  trapezoid_span_rasterizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (offer.func),
    .in_top_left_x    (offer.top_left_x),
    .in_top_right_x   (offer.top_right_x),
    .in_bottom_left_x (offer.bottom_left_x),
    .in_bottom_right_x(offer.bottom_right_x),
    .in_top_y         (offer.top_y),
    .in_bottom_y      (offer.bottom_y),
    .in_fill_color    (offer.fill_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span_left_x  (out_span_left_x),
    .out_span_right_x (out_span_right_x),
    .out_span_row     (out_span_row),
    .out_span_color   (out_span_color),
    .out_last_span    (out_last_span),
    .out_span_valid   (out_span_valid)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Note accepted words and check accepted spans
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      book.take_word(offer);
      words_in++;
    end
    if (rst_n && out_valid && out_ready)
      book.match_span({out_span_left_x, out_span_right_x, out_span_row, out_span_color,
                       out_last_span, out_span_valid});
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: random back-pressure plus one long hold-off
  initial begin : drain
    int pause;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!long_hold_done && words_in >= 120) begin
        out_ready = 1'b0;
        repeat (200) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        pause = steady ? 0 : pick_gap();
        if (pause > 0) begin
          out_ready = 1'b0;
          repeat (pause) @(negedge clk);
        end
      end
      out_ready = 1'b1;
      @(negedge clk);
    end
  end

  // Offer one word after an optional gap and hold it until accepted
  task automatic send_word(input word_t w);
    int pause;
    pause = steady ? 0 : pick_gap();
    if (pause > 0) begin
      in_valid = 1'b0;
      repeat (pause) @(negedge clk);
    end
    offer    = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic begin_trap(input logic [CB-1:0] tlx, input logic [CB-1:0] trx,
                            input logic [CB-1:0] blx, input logic [CB-1:0] brx,
                            input logic [CB-1:0] ty, input logic [CB-1:0] by,
                            input logic [KB-1:0] color);
    send_word({tsr_pkg::FUNC_BEGIN, tlx, trx, blx, brx, ty, by, color});
  endtask

  // Next-span word; the begin-only fields carry random junk
  task automatic next_span();
    word_t w;
    w      = WB'({$urandom, $urandom});
    w.func = tsr_pkg::FUNC_NEXT;
    send_word(w);
  endtask

  initial begin : stimulus
    int           h;
    int           rows;
    int           ty;
    int           by;
    bit           tall_done;
    bit           drained;
    word_t        w;
    book      = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    offer     = '0;
    steady    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // next with no fill since reset
    next_span();
    // flat trapezoids at both extremes, then next after the fill is done
    begin_trap(0, 255, 0, 255, 255, 255, 255);
    next_span();
    begin_trap(0, 0, 0, 0, 0, 0, 0);
    // shallow crossing edges, plus one extra next past the last row
    begin_trap(0, 255, 255, 0, 0, 3, 8'haa);
    repeat (4) next_span();
    // steep edges walking upward, abandoned by a new begin
    begin_trap(100, 200, 101, 200, 200, 195, 8'h55);
    repeat (2) next_span();
    // diagonal edges, dx equal to dy
    begin_trap(5, 250, 9, 246, 20, 24, 1);
    repeat (4) next_span();

    // Random part: mostly whole trapezoids, some noise and cut-short fills
    while (sent < 500) begin
      steady = (sent >= 420 && sent < 470);
      if (!drained && sent >= 350) begin
        // hold the input until every span is out
        in_valid = 1'b0;
        while (book.pending() != 0) @(negedge clk);
        drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 12 && tall_done) begin
        w = WB'({$urandom, $urandom});
        send_word(w);
      end else begin
        if (!tall_done) begin
          h  = 255;
          ty = $urandom_range(0, 1) ? 0 : 255;
          by = 255 - ty;
          tall_done = 1'b1;
        end else begin
          h  = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 12) : $urandom_range(13, 48);
          ty = $urandom_range(0, 255);
          if (($urandom_range(0, 1) && ty + h <= 255) || ty < h) by = ty + h;
          else by = ty - h;
        end
        begin_trap(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                   CB'(ty), CB'(by), KB'($urandom));
        rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, h) : h;
        repeat (rows) next_span();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) next_span();
      end
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    // let the last spans drain, then watch for strays
    while (book.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (book.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tsr_pkg.sv
rtl/core/tsr_ctrl.sv
rtl/core/tsr_datapath.sv
rtl/core/trapezoid_span_rasterizer.sv
rtl/core/tsr_checker.sv
verif/tb_top.sv
